[hw/rtl/dhs_pkg.sv]
// Shared types and constants for the dedup hash set.
package dhs_pkg;

   localparam int KEY_W        = 32;
   localparam int COUNT_W      = 13;
   localparam int BUCKETS_DEF  = 1024;
   localparam int WAYS_DEF     = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ST_NEW  = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

endpackage

[hw/rtl/dhs_if.sv]
// Valid/ready channel interfaces for the request and response streams.
interface dhs_req_if
   import dhs_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface dhs_rsp_if
   import dhs_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] number_out;
   status_type              status;
   logic [COUNT_W-1:0]      unique_count;

   modport source (output valid, output number_out, output status, output unique_count,
                   input ready);
   modport sink   (input valid, input number_out, input status, input unique_count,
                   output ready);
endinterface

[hw/rtl/dhs_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module dhs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/dhs_bucket_map.sv]
// Maps a 32-bit key to its bucket: key modulo the bucket count.
module dhs_bucket_map
   import dhs_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_W-1:0]           key,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] bucket
);

   localparam int BW = $clog2(BUCKETS);
   localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   if (POW2) begin : g_mask
      // power of two: the remainder is the low bits
      assign done   = start;
      assign bucket = key[BW-1:0];
   end else begin : g_recip
      // reciprocal estimate: the quotient is exact or one short, so the
      // remainder lands below twice the bucket count and needs one subtract
      localparam longint unsigned RECIP_L = (64'd1 << KEY_W) / 64'(BUCKETS);
      localparam logic [KEY_W-1:0] RECIP_C = KEY_W'(RECIP_L);
      localparam logic [BW:0]      B_C     = (BW+1)'(BUCKETS);

      logic [2*KEY_W-1:0] prod;
      logic [BW:0]        qb, diff, rem_wide;
      logic [KEY_W-1:0]   quot_ff;
      logic [BW:0]        low_ff;
      logic [BW-1:0]      rem_ff, rem_in;
      logic               stage_ff, done_ff;

      always_comb begin
         prod     = (2*KEY_W)'(key) * (2*KEY_W)'(RECIP_C);
         // only the low bits matter: the true remainder fits in BW+1 bits
         qb       = quot_ff[BW:0] * B_C;
         diff     = low_ff - qb;
         rem_wide = (diff >= B_C) ? diff - B_C : diff;
         rem_in   = rem_wide[BW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff <= 1'b0;
            done_ff  <= 1'b0;
         end else begin
            stage_ff <= start;
            done_ff  <= stage_ff;
         end
         if (start) begin
            quot_ff <= prod[2*KEY_W-1:KEY_W];
            low_ff  <= key[BW:0];
         end
         if (stage_ff) begin
            rem_ff <= rem_in;
         end
      end

      assign done   = done_ff;
      assign bucket = rem_ff;
   end

endmodule

[hw/rtl/dedup_hash_set_insert.sv]
// Top level of the dedup hash set: bucket lookup, way compare and write-back.
//
//  channel  | dir | payload                                  | handshake
//  req_if   | in  | number (s32)                             | valid/ready
//  rsp_if   | out | number_out (s32), status, unique_count   | valid/ready
//
//  When BUCKETS is a power of two, an item has its bucket row read, then all ways compared
//  and the row written back. Otherwise the remainder unit first registers a reciprocal
//  multiply, then applies one correcting subtract, before the read.
//  After reset a clearing pass writes every bucket row to zero with req_if.ready low.
//  One response register sits on the output: a new request is taken
//  while a response waits; the compare stage holds when that register is still full.
module dedup_hash_set_insert
   import dhs_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int WAYS    = WAYS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dhs_req_if.sink   req_if,
   dhs_rsp_if.source rsp_if
);

   localparam int BW    = $clog2(BUCKETS);
   localparam int ROW_W = WAYS * (KEY_W + 1);
   localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_CHECK
   } state_type;

   state_type          state_ff;
   logic [BW-1:0]      clr_ff;
   logic               start_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [BW-1:0]      bucket_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff;
   logic [KEY_W-1:0]   rsp_number_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               map_done;
   logic [BW-1:0]      map_bucket;

   logic               mem_we, mem_re;
   logic [BW-1:0]      mem_waddr;
   logic [ROW_W-1:0]   mem_wdata, mem_rdata;

   logic [WAYS-1:0]    way_valid, free_oh;
   logic               hit, have_free, rsp_free, req_fire;
   logic [ROW_W-1:0]   wr_row;
   status_type         ck_status;
   logic [COUNT_W-1:0] count_in;

   dhs_bucket_map #(
      .BUCKETS (BUCKETS)
   ) u_map (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .key    (key_ff),
      .done   (map_done),
      .bucket (map_bucket)
   );

   // one row per bucket: valid bits low, then one key per way
   dhs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (map_bucket),
      .rd_data (mem_rdata)
   );

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) || (state_ff == S_CHECK && rsp_free);
   assign req_fire = req_if.valid && req_if.ready;

   // compare all ways; pick the lowest free one
   always_comb begin
      way_valid = mem_rdata[WAYS-1:0];
      hit = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (way_valid[w] && mem_rdata[WAYS + w*KEY_W +: KEY_W] == key_ff) begin
            hit = 1'b1;
         end
      end
      free_oh   = ~way_valid & (way_valid + 1'b1);
      have_free = |free_oh;
      wr_row    = mem_rdata;
      wr_row[WAYS-1:0] = way_valid | free_oh;
      for (int w = 0; w < WAYS; w++) begin
         if (free_oh[w]) begin
            wr_row[WAYS + w*KEY_W +: KEY_W] = key_ff;
         end
      end
      if (hit) begin
         ck_status = ST_DUP;
      end else if (have_free) begin
         ck_status = ST_NEW;
      end else begin
         ck_status = ST_FULL;
      end
      count_in = count_ff;
      if (ck_status == ST_NEW && count_ff != COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = bucket_ff;
      mem_wdata = wr_row;
      mem_re    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         S_HASH: begin
            mem_re = map_done;
         end
         S_CHECK: begin
            mem_we = rsp_free && ck_status == ST_NEW;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         start_ff <= req_fire;
         if (req_fire) begin
            key_ff <= req_if.number;
         end
         if (state_ff == S_CHECK && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_BKT) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (map_done) begin
                  bucket_ff <= map_bucket;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               // hold until the response register is free
               if (rsp_free) begin
                  rsp_number_ff <= key_ff;
                  rsp_status_ff <= ck_status;
                  rsp_count_ff  <= count_in;
                  count_ff      <= count_in;
                  state_ff      <= req_fire ? S_HASH : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.number_out   = rsp_number_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.unique_count = rsp_count_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_if.ready)
      else $error("request taken during clearing pass");

   a_write_only_when_owned: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_CHECK))
      else $error("row write outside clear or check");

   a_hit_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && hit) |-> !mem_we)
      else $error("duplicate key written back");

   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && rsp_free && ck_status == ST_NEW && count_ff != COUNT_MAX)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("unique count did not advance on new key");

endmodule

[sim/dedup_hash_set_insert_tb.sv]
// Self-checking testbench for the dedup hash set: random stalls, scoreboard, watchdog.
`timescale 1ns / 1ps

module dedup_hash_set_insert_tb;
   import dhs_pkg::*;

   localparam int N_BUCKETS  = BUCKETS_DEF;
   localparam int N_WAYS     = WAYS_DEF;
   localparam int N_ENTRIES  = N_BUCKETS * N_WAYS;
   localparam int N_RANDOM   = 2000;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [KEY_W-1:0] number;
      status_type              status;
      logic [COUNT_W-1:0]      count;
   } insert_result_type;

   logic clock;
   logic reset;

   dhs_req_if req_bus ();
   dhs_rsp_if rsp_bus ();

   dedup_hash_set_insert #(
      .BUCKETS (N_BUCKETS),
      .WAYS    (N_WAYS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // shadow copy of the set
   logic [KEY_W-1:0]   shadow_keys [N_ENTRIES];
   bit                 shadow_valid [N_ENTRIES];
   logic [COUNT_W-1:0] shadow_total;

   logic signed [KEY_W-1:0] pending_numbers [$];
   insert_result_type       expected_results [$];

   int          mismatches = 0;
   int          requests_taken = 0;
   int          total_items = 0;
   int unsigned responses_seen;
   int unsigned cycle_count;
   int unsigned idle_cycles;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (response %0d)", what, got, want,
               responses_seen);
      mismatches++;
   endtask

   // mirror one insert into the shadow set and queue the result it must produce
   function automatic void predict_insert(input logic signed [KEY_W-1:0] num);
      logic [KEY_W-1:0]  raw;
      int unsigned       base;
      bit                hit;
      bit                have_free;
      int unsigned       free_slot;
      insert_result_type res;
      raw       = num;
      base      = (raw % unsigned'(N_BUCKETS)) * N_WAYS;
      hit       = 0;
      have_free = 0;
      free_slot = 0;
      for (int w = 0; w < N_WAYS; w++) begin
         if (shadow_valid[base + w]) begin
            if (shadow_keys[base + w] == raw) hit = 1;
         end else if (!have_free) begin
            have_free = 1;
            free_slot = base + w;
         end
      end
      if (hit) begin
         res.status = ST_DUP;
      end else if (have_free) begin
         shadow_keys[free_slot]  = raw;
         shadow_valid[free_slot] = 1;
         if (shadow_total != COUNT_MAX) shadow_total++;
         res.status = ST_NEW;
      end else begin
         res.status = ST_FULL;
      end
      res.number = num;
      res.count  = shadow_total;
      expected_results.push_back(res);
   endfunction

   // idle length: mostly none, sometimes short, rarely long; none in calm windows
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if ((cycle_count % 1024) < 200) return 0;
      if (r < 75) return 0;
      if (r < 93) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: one beat per pending number, random gap after each
   int unsigned send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.number <= '0;
         send_gap       <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (pending_numbers.size() != 0) begin
            req_bus.valid  <= 1'b1;
            req_bus.number <= pending_numbers.pop_front();
            send_gap       <= idle_len();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready: random stalls plus one long hold-off to back up the block
   int unsigned stall_left;
   int unsigned hold_left;
   bit          hold_done;
   always @(posedge clock) begin : ready_gen
      int unsigned len;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         hold_left     <= 0;
         hold_done     <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_done && responses_seen >= 600) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         len = idle_len();
         rsp_bus.ready <= (len == 0);
         if (len != 0) stall_left <= len - 1;
      end
   end

   // monitor: check response beats, then predict for accepted request beats
   always @(posedge clock) begin : monitor
      insert_result_type want;
      if (reset) begin
         responses_seen <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response, number", rsp_bus.number_out, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.number_out !== want.number)
                  report_mismatch("number_out", rsp_bus.number_out, want.number);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", rsp_bus.status, want.status);
               if (rsp_bus.unique_count !== want.count)
                  report_mismatch("unique_count", rsp_bus.unique_count, want.count);
            end
            responses_seen <= responses_seen + 1;
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_insert(req_bus.number);
            requests_taken++;
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [KEY_W-1:0]  hot_buckets [8];
      logic [KEY_W-1:0]  hi;
      logic [KEY_W-1:0]  num;
      int unsigned       kind;
      for (int i = 0; i < N_ENTRIES; i++) shadow_valid[i] = 0;
      shadow_total = '0;

      // extremes, repeats, negative hashing, and one bucket driven to full
      pending_numbers = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sd0, -32'sd1, 32'sh8000_03FF,
                          32'sd5, 32'sd1029, 32'sd2053, 32'sd3077, 32'sd4101,
                          32'sd1029, 32'sh8000_0005, -32'sd1019, 32'sd3077,
                          32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555};

      hot_buckets[0] = 5;
      hot_buckets[1] = N_BUCKETS - 1;
      for (int i = 2; i < 8; i++) hot_buckets[i] = $urandom_range(0, N_BUCKETS - 1);

      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            num = $urandom;
         end else if (kind < 60) begin
            num = pending_numbers[$urandom_range(0, pending_numbers.size() - 1)];
         end else if (kind < 88) begin
            // crowd a few buckets so they fill and start dropping
            hi = $urandom_range(0, 9);
            if ($urandom_range(0, 1)) hi = ~hi;
            num = hi * N_BUCKETS + hot_buckets[$urandom_range(0, 7)];
         end else begin
            num = $urandom_range(0, 127) - 64;
         end
         pending_numbers.push_back(num);
      end
      total_items = pending_numbers.size();

      while (requests_taken < total_items || expected_results.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dhs_pkg.sv
hw/rtl/dhs_if.sv
hw/rtl/dhs_ram.sv
hw/rtl/dhs_bucket_map.sv
hw/rtl/dedup_hash_set_insert.sv
sim/dedup_hash_set_insert_tb.sv
